/* rtl/pfr_pkg.sv */
// Package for the page frame replacement block.
// Holds the table sizes, the frame entry layout, the policy codes and the tally event group.
// No dependencies.
package pfr_pkg;

  localparam int unsigned FRAMES = 64;
  localparam int unsigned IDX_W  = $clog2(FRAMES);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned PAGE_W = 20;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TALLY_W = 32;

  // Policy register codes.
  localparam logic [1:0] POL_FIFO  = 2'd0;
  localparam logic [1:0] POL_CLOCK = 2'd1;
  localparam logic [1:0] POL_LRU   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_FRAMES = 1'b1;

  // One frame table entry as stored in the frame memory.
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [TIME_W-1:0] loaded_at;
    logic [TIME_W-1:0] touched_at;
  } frame_t;

  // Events that advance the running totals.
  typedef struct packed {
    logic access;
    logic miss;
    logic writeback;
    logic drop;
  } tally_ev_t;

endpackage

/* rtl/pfr_frame_ram.sv */
// Frame table memory: one write port and one read port, read data registered.
// Depends on pfr_pkg for the depth and the entry layout.
module pfr_frame_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [pfr_pkg::IDX_W-1:0] waddr_i,
  input  pfr_pkg::frame_t          wdata_i,
  input  logic [pfr_pkg::IDX_W-1:0] raddr_i,
  output pfr_pkg::frame_t          rdata_o
);

  pfr_pkg::frame_t mem [pfr_pkg::FRAMES];
  pfr_pkg::frame_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pfr_tally.sv */
// Saturating running totals of accesses, misses, writebacks and drops.
// Depends on pfr_pkg for the counter width and the event group.
module pfr_tally (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfr_pkg::tally_ev_t          ev_i,
  output logic [pfr_pkg::TALLY_W-1:0] access_o,
  output logic [pfr_pkg::TALLY_W-1:0] miss_o,
  output logic [pfr_pkg::TALLY_W-1:0] writeback_o,
  output logic [pfr_pkg::TALLY_W-1:0] drop_o
);

  logic [pfr_pkg::TALLY_W-1:0] access_q, miss_q, writeback_q, drop_q;

  // Each counter stops at its top value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_q    <= '0;
      miss_q      <= '0;
      writeback_q <= '0;
      drop_q      <= '0;
    end else begin
      if (ev_i.access && (access_q != '1)) access_q <= access_q + 1'b1;
      if (ev_i.miss && (miss_q != '1)) miss_q <= miss_q + 1'b1;
      if (ev_i.writeback && (writeback_q != '1)) writeback_q <= writeback_q + 1'b1;
      if (ev_i.drop && (drop_q != '1)) drop_q <= drop_q + 1'b1;
    end
  end

  assign access_o    = access_q;
  assign miss_o      = miss_q;
  assign writeback_o = writeback_q;
  assign drop_o      = drop_q;

endmodule

/* rtl/page_frame_replacement.sv */
// Page frame replacement table with FIFO, CLOCK and LRU victim selection.
// Each accepted input transaction starts a scan with one read of the frame memory per active
// frame, then, when CLOCK has to evict, a hand reduction and a hand step walk, then a read
// and a write of the chosen entry before the result is shown.
// One access at a time: the next is taken the cycle after the result has been accepted.
// Reset: asynchronous, active low; clears valid, dirty and use bits, hand, time and totals.
module page_frame_replacement (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input transaction: tdata = page_number[19:0], zero fill; tuser = is_write.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [23:0]   s_axis_tdata,
  input  logic          s_axis_tuser,
  // Result transaction: tdata = hit, frame_slot[5:0], evicted, evicted_page[19:0],
  // evicted_dirty, access_count, miss_count, writeback_count, drop_count, zero fill.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [159:0]  m_axis_tdata,
  // Configuration write port.
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [6:0]    cfg_wdata_i
);

  localparam int unsigned IW = pfr_pkg::IDX_W;
  localparam int unsigned CW = pfr_pkg::CNT_W;
  localparam int unsigned TW = pfr_pkg::TIME_W;
  localparam int unsigned PW = pfr_pkg::PAGE_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_HMOD = 7'b0000100,
    ST_WALK = 7'b0001000,
    ST_RD   = 7'b0010000,
    ST_WR   = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration.
  logic [1:0]    policy_q;
  logic [CW-1:0] fiu_q;
  logic [CW-1:0] n_act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= pfr_pkg::POL_FIFO;
      fiu_q    <= CW'(pfr_pkg::FRAMES);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfr_pkg::CFG_POLICY: policy_q <= cfg_wdata_i[1:0];
        pfr_pkg::CFG_FRAMES: fiu_q <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Active frame count, clamped to 1..FRAMES.
  always_comb begin
    if (fiu_q == '0) n_act = CW'(1);
    else if (fiu_q > CW'(pfr_pkg::FRAMES)) n_act = CW'(pfr_pkg::FRAMES);
    else n_act = fiu_q;
  end

  // Per-frame flag bits and global state.
  logic [pfr_pkg::FRAMES-1:0] valid_q, dirty_q, used_q;
  logic [IW-1:0]              hand_q;
  logic [TW-1:0]              now_q;

  // Request and scan results.
  logic [PW-1:0] req_page_q;
  logic          req_wr_q;
  logic [CW-1:0] iss_q;
  logic          rv_q;
  logic [IW-1:0] ri_q;
  logic          hit_q, free_q;
  logic [IW-1:0] hit_idx_q, free_idx_q, fifo_idx_q, lru_idx_q, walk_q, slot_q;
  logic [TW-1:0] fifo_min_q, lru_min_q;

  // Result fields.
  logic          o_hit_q, o_ev_q, o_evd_q;
  logic [IW-1:0] o_slot_q;
  logic [PW-1:0] o_evp_q;
  logic          out_vld_q;

  pfr_pkg::frame_t rdata, wdata;
  logic            ram_we;
  logic [IW-1:0]   raddr;
  pfr_pkg::tally_ev_t tev;
  logic [pfr_pkg::TALLY_W-1:0] t_acc, t_miss, t_wb, t_drop;

  logic          in_acc;
  logic          scan_done;
  logic [IW-1:0] walk_nxt;
  logic          do_evict;

  // A waiting result holds off the next access so that its fields and totals stay stable.
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !out_vld_q;
  assign scan_done = (iss_q == n_act) && !rv_q;
  assign walk_nxt  = (({1'b0, walk_q} + CW'(1)) == n_act) ? '0 : walk_q + 1'b1;
  assign do_evict  = !hit_q && !free_q;

  // Frame memory read address: scan sweep, then the chosen slot.
  assign raddr = (state_q == ST_SCAN) ? iss_q[IW-1:0] : slot_q;

  pfr_frame_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Write back the entry: a hit keeps page and load time, a miss installs the new page.
  always_comb begin
    ram_we = (state_q == ST_WR);
    wdata.page       = hit_q ? rdata.page : req_page_q;
    wdata.loaded_at  = hit_q ? rdata.loaded_at : now_q;
    wdata.touched_at = now_q;
    tev.access    = (state_q == ST_WR);
    tev.miss      = (state_q == ST_WR) && !hit_q;
    tev.writeback = (state_q == ST_WR) && do_evict && dirty_q[slot_q];
    tev.drop      = (state_q == ST_WR) && do_evict && !dirty_q[slot_q];
  end

  pfr_tally u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (tev),
    .access_o    (t_acc),
    .miss_o      (t_miss),
    .writeback_o (t_wb),
    .drop_o      (t_drop)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          if (hit_q || free_q) state_d = ST_RD;
          else if (policy_q == pfr_pkg::POL_CLOCK) state_d = ST_HMOD;
          else state_d = ST_RD;
        end
      end
      ST_HMOD: if ({1'b0, hand_q} < n_act) state_d = ST_WALK;
      ST_WALK: if (!used_q[walk_q]) state_d = ST_RD;
      ST_RD:   state_d = ST_WR;
      ST_WR:   state_d = ST_OUT;
      ST_OUT:  if (!out_vld_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Control registers: flags, hand, time, scan pipeline and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      dirty_q   <= '0;
      used_q    <= '0;
      hand_q    <= '0;
      now_q     <= '0;
      iss_q     <= '0;
      rv_q      <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) out_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          iss_q  <= '0;
          rv_q   <= 1'b0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
        end
        ST_SCAN: begin
          // Issue one read per cycle; evaluate the entry returned from the last read.
          rv_q <= (iss_q != n_act);
          if (iss_q != n_act) iss_q <= iss_q + 1'b1;
          if (rv_q) begin
            if (valid_q[ri_q] && (rdata.page == req_page_q) && !hit_q) hit_q <= 1'b1;
            if (!valid_q[ri_q] && !free_q) free_q <= 1'b1;
          end
        end
        ST_HMOD: if ({1'b0, hand_q} >= n_act) hand_q <= hand_q - n_act[IW-1:0];
        ST_WALK: begin
          if (used_q[walk_q]) used_q[walk_q] <= 1'b0;
          else hand_q <= walk_nxt;
        end
        ST_WR: begin
          used_q[slot_q]  <= 1'b1;
          valid_q[slot_q] <= 1'b1;
          if (hit_q) dirty_q[slot_q] <= dirty_q[slot_q] | req_wr_q;
          else dirty_q[slot_q] <= req_wr_q;
          if (now_q != '1) now_q <= now_q + 1'b1;
        end
        ST_OUT: if (!out_vld_q || m_axis_tready) out_vld_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers: request, scan bests, chosen slot and result fields.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        req_page_q <= s_axis_tdata[PW-1:0];
        req_wr_q   <= s_axis_tuser;
      end
      ST_SCAN: begin
        ri_q <= iss_q[IW-1:0];
        if (rv_q) begin
          if (valid_q[ri_q] && (rdata.page == req_page_q) && !hit_q) hit_idx_q <= ri_q;
          if (!valid_q[ri_q] && !free_q) free_idx_q <= ri_q;
          // Oldest load and access stamps; strict compare keeps the lowest index on ties.
          if ((ri_q == '0) || (rdata.loaded_at < fifo_min_q)) begin
            fifo_min_q <= rdata.loaded_at;
            fifo_idx_q <= ri_q;
          end
          if ((ri_q == '0) || (rdata.touched_at < lru_min_q)) begin
            lru_min_q <= rdata.touched_at;
            lru_idx_q <= ri_q;
          end
        end
        if (scan_done) begin
          if (hit_q) slot_q <= hit_idx_q;
          else if (free_q) slot_q <= free_idx_q;
          else if (policy_q == pfr_pkg::POL_LRU) slot_q <= lru_idx_q;
          else slot_q <= fifo_idx_q;
        end
      end
      ST_HMOD: walk_q <= ({1'b0, hand_q} >= n_act) ? hand_q - n_act[IW-1:0] : hand_q;
      ST_WALK: begin
        if (used_q[walk_q]) walk_q <= walk_nxt;
        else slot_q <= walk_q;
      end
      ST_WR: begin
        o_hit_q  <= hit_q;
        o_slot_q <= slot_q;
        o_ev_q   <= do_evict;
        o_evp_q  <= do_evict ? rdata.page : '0;
        o_evd_q  <= do_evict && dirty_q[slot_q];
      end
      default: ;
    endcase
  end

  // Result transaction; totals are already updated when the result is shown.
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, t_drop, t_wb, t_miss, t_acc,
                          o_evd_q, o_evp_q, o_ev_q, o_slot_q, o_hit_q};

endmodule

/* test/testbench.sv */
// Self-checking testbench for the page frame replacement table.
// Drives random and directed page accesses under FIFO, CLOCK and LRU and checks each result
// against an in-bench model of the frame table. Depends on pfr_pkg and page_frame_replacement.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [pfr_pkg::PAGE_W-1:0] page;
    logic                       wr;
  } access_t;

  typedef struct packed {
    logic [31:0]                drops;
    logic [31:0]                writebacks;
    logic [31:0]                misses;
    logic [31:0]                accesses;
    logic                       ev_dirty;
    logic [pfr_pkg::PAGE_W-1:0] ev_page;
    logic                       evicted;
    logic [pfr_pkg::IDX_W-1:0]  slot;
    logic                       hit;
  } outcome_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = pfr_pkg::CFG_POLICY;
  logic [6:0]   cfg_wdata_i = '0;

  page_frame_replacement i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Model of the frame table.
  logic [pfr_pkg::PAGE_W-1:0] m_page [pfr_pkg::FRAMES];
  logic              m_valid [pfr_pkg::FRAMES];
  logic              m_dirty [pfr_pkg::FRAMES];
  logic              m_used [pfr_pkg::FRAMES];
  logic [31:0]       m_loaded [pfr_pkg::FRAMES];
  logic [31:0]       m_touched [pfr_pkg::FRAMES];
  int unsigned       m_hand;
  logic [31:0]       m_now;
  logic [31:0]       m_tally [4];
  logic [1:0]        m_policy;
  logic [6:0]        m_frames;

  access_t  pending_accesses[$];
  outcome_t expected_outcomes[$];
  int       errors = 0;
  int       cycle = 0;
  bit       hold_off_req = 1'b0;
  bit       sender_paused = 1'b0;
  int       sent = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int unsigned oldest_slot(ref logic [31:0] stamp [pfr_pkg::FRAMES],
                                              input int unsigned n);
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < n; i++)
      if (stamp[i] < stamp[best]) best = i;
    return best;
  endfunction

  // Computes the result of one access and updates the model state.
  function automatic outcome_t predict_access(access_t a);
    outcome_t    o;
    int unsigned n, slot;
    bit          found, free_found;
    n = (m_frames == 0) ? 1 : (m_frames > pfr_pkg::FRAMES) ? pfr_pkg::FRAMES : m_frames;
    o = '0;
    found = 1'b0;
    slot = 0;
    for (int unsigned i = 0; i < n; i++)
      if (!found && m_valid[i] && m_page[i] == a.page) begin
        found = 1'b1;
        slot = i;
      end
    if (found) begin
      if (a.wr) m_dirty[slot] = 1'b1;
      m_touched[slot] = m_now;
      m_used[slot] = 1'b1;
    end else begin
      free_found = 1'b0;
      for (int unsigned i = 0; i < n; i++)
        if (!free_found && !m_valid[i]) begin
          free_found = 1'b1;
          slot = i;
        end
      if (!free_found) begin
        if (m_policy == pfr_pkg::POL_CLOCK) begin
          m_hand = m_hand % n;
          while (m_used[m_hand]) begin
            m_used[m_hand] = 1'b0;
            m_hand = (m_hand + 1) % n;
          end
          slot = m_hand;
          m_hand = (m_hand + 1) % n;
        end else if (m_policy == pfr_pkg::POL_LRU) begin
          slot = oldest_slot(m_touched, n);
        end else begin
          slot = oldest_slot(m_loaded, n);
        end
        o.evicted = 1'b1;
        o.ev_page = m_page[slot];
        o.ev_dirty = m_dirty[slot];
        if (m_dirty[slot]) m_tally[2] = sat_inc(m_tally[2]);
        else m_tally[3] = sat_inc(m_tally[3]);
      end
      m_page[slot] = a.page;
      m_valid[slot] = 1'b1;
      m_used[slot] = 1'b1;
      m_dirty[slot] = a.wr;
      m_loaded[slot] = m_now;
      m_touched[slot] = m_now;
      m_tally[1] = sat_inc(m_tally[1]);
    end
    m_tally[0] = sat_inc(m_tally[0]);
    m_now = sat_inc(m_now);
    o.hit = found;
    o.slot = slot[pfr_pkg::IDX_W-1:0];
    o.accesses = m_tally[0];
    o.misses = m_tally[1];
    o.writebacks = m_tally[2];
    o.drops = m_tally[3];
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: offers queued accesses and predicts each one when it is taken.
  int src_gap = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_outcomes.push_back(
        predict_access({s_axis_tdata[pfr_pkg::PAGE_W-1:0], s_axis_tuser}));
      sent++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_accesses.size() > 0 && !sender_paused) begin
        access_t a;
        a = pending_accesses.pop_front();
        s_axis_tdata <= {4'h0, a.page};
        s_axis_tuser <= a.wr;
        s_axis_tvalid <= 1'b1;
        src_gap <= gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and a long hold-off on request.
  int sink_gap = 0;
  int hold_count = 0;
  always @(posedge clk_i) begin
    cycle++;
    if (cycle > 2_000_000) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      outcome_t act, exp_o;
      act = m_axis_tdata[$bits(outcome_t)-1:0];
      if (expected_outcomes.size() == 0) begin
        $error("result with no access outstanding");
        errors++;
      end else begin
        exp_o = expected_outcomes.pop_front();
        if (act.hit != exp_o.hit) begin
          $error("hit: expected %0d actual %0d", exp_o.hit, act.hit); errors++; end
        if (act.slot != exp_o.slot) begin
          $error("frame_slot: expected %0d actual %0d", exp_o.slot, act.slot); errors++; end
        if (act.evicted != exp_o.evicted) begin
          $error("evicted: expected %0d actual %0d", exp_o.evicted, act.evicted); errors++; end
        if (act.ev_page != exp_o.ev_page) begin
          $error("evicted_page: expected %0h actual %0h", exp_o.ev_page, act.ev_page);
          errors++; end
        if (act.ev_dirty != exp_o.ev_dirty) begin
          $error("evicted_dirty: expected %0d actual %0d", exp_o.ev_dirty, act.ev_dirty);
          errors++; end
        if (act.accesses != exp_o.accesses) begin
          $error("access_count: expected %0d actual %0d", exp_o.accesses, act.accesses);
          errors++; end
        if (act.misses != exp_o.misses) begin
          $error("miss_count: expected %0d actual %0d", exp_o.misses, act.misses); errors++; end
        if (act.writebacks != exp_o.writebacks) begin
          $error("writeback_count: expected %0d actual %0d", exp_o.writebacks, act.writebacks);
          errors++; end
        if (act.drops != exp_o.drops) begin
          $error("drop_count: expected %0d actual %0d", exp_o.drops, act.drops); errors++; end
      end
    end
    if (hold_off_req && hold_count == 0) begin
      hold_count <= 400;
      hold_off_req <= 1'b0;
      m_axis_tready <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      m_axis_tready <= (hold_count == 1);
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_gap <= gap_len();
    end
  end

  task automatic write_reg(logic idx, logic [6:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == pfr_pkg::CFG_POLICY) m_policy = val[1:0];
    else m_frames = val;
  endtask

  // Waits until every queued access is sent and answered, then lets the block settle.
  task automatic drain();
    while (pending_accesses.size() > 0 || s_axis_tvalid || expected_outcomes.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Random accesses drawn from a small working set with occasional far pages.
  task automatic queue_random(int count, int span);
    access_t a;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) a.page = 20'($urandom_range(0, 20'hFFFFF));
      else a.page = 20'h80 + 20'($urandom_range(0, span - 1));
      a.wr = 1'($urandom_range(0, 1));
      pending_accesses.push_back(a);
    end
  endtask

  initial begin
    logic [1:0] pols [6];
    logic [6:0] sizes [6];
    for (int i = 0; i < pfr_pkg::FRAMES; i++) begin
      m_valid[i] = 1'b0; m_dirty[i] = 1'b0; m_used[i] = 1'b0;
      m_page[i] = '0; m_loaded[i] = '0; m_touched[i] = '0;
    end
    for (int i = 0; i < 4; i++) m_tally[i] = '0;
    m_hand = 0; m_now = '0; m_policy = pfr_pkg::POL_FIFO; m_frames = 7'd64;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme pages, hits, dirtying writes and evictions in a two-frame table.
    write_reg(pfr_pkg::CFG_FRAMES, 7'd2);
    write_reg(pfr_pkg::CFG_POLICY, 7'(pfr_pkg::POL_FIFO));
    pending_accesses.push_back('{page: 20'h00000, wr: 1'b0});
    pending_accesses.push_back('{page: 20'hFFFFF, wr: 1'b1});
    pending_accesses.push_back('{page: 20'h00000, wr: 1'b1});
    pending_accesses.push_back('{page: 20'hFFFFF, wr: 1'b0});
    pending_accesses.push_back('{page: 20'h55555, wr: 1'b0});
    pending_accesses.push_back('{page: 20'hAAAAA, wr: 1'b1});
    pending_accesses.push_back('{page: 20'h55555, wr: 1'b0});
    pending_accesses.push_back('{page: 20'h12345, wr: 1'b0});
    drain();
    // Unused policy code and a frame count of zero.
    write_reg(pfr_pkg::CFG_POLICY, 7'd3);
    write_reg(pfr_pkg::CFG_FRAMES, 7'd0);
    pending_accesses.push_back('{page: 20'h00001, wr: 1'b1});
    pending_accesses.push_back('{page: 20'h00002, wr: 1'b0});
    pending_accesses.push_back('{page: 20'h00002, wr: 1'b1});
    drain();
    // Frame count above the built depth under CLOCK, then a three-frame CLOCK table.
    write_reg(pfr_pkg::CFG_FRAMES, 7'd127);
    write_reg(pfr_pkg::CFG_POLICY, 7'(pfr_pkg::POL_CLOCK));
    queue_random(12, 8);
    drain();
    write_reg(pfr_pkg::CFG_FRAMES, 7'd3);
    queue_random(10, 6);
    drain();

    // Random phases over the policies and table sizes.
    pols = '{pfr_pkg::POL_FIFO, pfr_pkg::POL_CLOCK, pfr_pkg::POL_LRU, pfr_pkg::POL_LRU,
             pfr_pkg::POL_CLOCK, pfr_pkg::POL_FIFO};
    sizes = '{7'd64, 7'd4, 7'd1, 7'd16, 7'd64, 7'd8};
    for (int p = 0; p < 6; p++) begin
      write_reg(pfr_pkg::CFG_POLICY, 7'(pols[p]));
      write_reg(pfr_pkg::CFG_FRAMES, sizes[p]);
      queue_random(300, (sizes[p] > 1) ? sizes[p] + sizes[p] / 2 : 3);
      if (p == 1) begin
        hold_off_req = 1'b1;
      end
      if (p == 3) begin
        // Sender pauses mid-phase until all outstanding results are back.
        while (pending_accesses.size() > 150) @(posedge clk_i);
        sender_paused = 1'b1;
        while (s_axis_tvalid || expected_outcomes.size() > 0) @(posedge clk_i);
        sender_paused = 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
